// ===== hw/rtl/kuf_pkg.sv =====
// ----------------------------------------------------------------------------
// kuf_pkg
// shared types and constants of the union-find edge filter
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

  // default capacity of the vertex store
  localparam int MAX_VERTICES_DEF = 256;

  // fixed field widths
  localparam int VERTEX_W  = 8;
  localparam int VCOUNT_W  = 9;
  localparam int SIZE_OUT_W = 9;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // register word index (paddr[2])
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

  typedef struct packed {
    logic                start_graph;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic                  edge_accepted;
    logic                  tree_done;
    logic [SIZE_OUT_W-1:0] merged_size;
    logic [VERTEX_W-1:0]   edge_from;
    logic [VERTEX_W-1:0]   edge_to;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FIND,
    ST_COMP,
    ST_UNION
  } kuf_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kruskal_union_find_edge_filter.sv =====
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// kruskal edge filter: union-find by size with full path compression
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ----------------------------
//  input     in         start & !busy           in_item  (edge, start flag)
//  result    out        out_valid, one cycle    out_item (verdict, sizes)
//  config    in/out     apb psel/penable/pwrite vertex_count at byte addr 0
//
//  a joining edge strobes its result after a find and a compression walk from
//  each vertex and the union write, a same-set edge or self loop without the
//  union write, an out-of-range edge or one after tree done from the check state;
//  each link costs one ram read in the find walk and one in the compression walk.
//  reset and every start_graph edge first run a clearing pass over every entry
//  with busy high; the receiver cannot stall, busy is low with the strobe.
//
`default_nettype none

module kruskal_union_find_edge_filter #(
  parameter int MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // edge input
  input  wire logic                        start,
  output logic                             busy,
  input  wire kuf_pkg::in_item_t           in_item,
  // result
  output logic                             out_valid,
  output kuf_pkg::out_item_t               out_item,
  // apb register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kuf_pkg::APB_AW-1:0]  paddr,
  input  wire logic [kuf_pkg::APB_DW-1:0]  pwdata,
  output logic      [kuf_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  // vertex index, set size and count widths
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (SW > kuf_pkg::VCOUNT_W) ? SW : kuf_pkg::VCOUNT_W;
  localparam int DW = VW + SW;

  localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);
  localparam logic [NW-1:0] MAX_N       = NW'(MAX_VERTICES);

  // sequencer and working registers
  kuf_pkg::kuf_state_t state_r, state_nxt;
  kuf_pkg::in_item_t   item_r, item_nxt;
  logic [VW-1:0]       cur_r, cur_nxt;        // node under the walk
  logic [VW-1:0]       root_r, root_nxt;      // root of the current find
  logic [VW-1:0]       ra_r, ra_nxt;          // root of the from vertex
  logic [SW-1:0]       sa_r, sa_nxt;          // size at ra
  logic [SW-1:0]       sb_r, sb_nxt;          // size at the to root
  logic                phase_b_r, phase_b_nxt; // second find under way
  logic [VW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_then_r, clr_then_nxt; // clear pass then edge
  logic                done_r, done_nxt;
  logic [kuf_pkg::SIZE_OUT_W-1:0] last_r, last_nxt;
  logic [kuf_pkg::VCOUNT_W-1:0]   vcount_r;
  logic                out_valid_r, out_valid_nxt;
  kuf_pkg::out_item_t  out_item_r, out_item_nxt;

  // ram ports: word = {parent, size}
  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [VW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [VW-1:0] rd_parent;
  logic [SW-1:0] rd_size;

  // decoded item and union terms
  logic [NW-1:0] vcount_ext;
  logic [NW-1:0] eff_n;
  logic          from_ok;
  logic          to_ok;
  logic [VW-1:0] from_idx;
  logic [VW-1:0] to_idx;
  logic [VW-1:0] start_idx;
  logic          a_under;         // from root goes under to root
  logic [VW-1:0] winner;
  logic [VW-1:0] loser;
  logic [SW-1:0] merged;
  logic          merged_full;
  logic          cfg_wr;

  assign rd_parent = ram_rdata[DW-1:SW];
  assign rd_size   = ram_rdata[SW-1:0];

  // zero counts as one, above capacity clamps to capacity
  assign vcount_ext = NW'(vcount_r);
  always_comb begin
    if (vcount_ext == '0) begin
      eff_n = NW'(1);
    end else if (vcount_ext > MAX_N) begin
      eff_n = MAX_N;
    end else begin
      eff_n = vcount_ext;
    end
  end

  assign from_ok   = NW'(item_r.from_vertex) < eff_n;
  assign to_ok     = NW'(item_r.to_vertex) < eff_n;
  assign from_idx  = VW'(item_r.from_vertex);
  assign to_idx    = VW'(item_r.to_vertex);
  assign start_idx = phase_b_r ? to_idx : from_idx;

  // root_r holds the to root once the second find is through
  assign a_under     = sa_r <= sb_r;
  assign winner      = a_under ? root_r : ra_r;
  assign loser       = a_under ? ra_r : root_r;
  assign merged      = sa_r + sb_r;
  assign merged_full = NW'(merged) >= eff_n;

  kuf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_forest (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    phase_b_nxt   = phase_b_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_then_nxt  = clr_then_r;
    done_nxt      = done_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = {root_r, rd_size};
    ram_raddr     = cur_r;

    case (state_r)
      // sweep every entry back to a singleton set
      kuf_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = {clr_cnt_r, SW'(1)};
        clr_cnt_nxt = clr_cnt_r + VW'(1);
        if (clr_cnt_r == LAST_VERTEX) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_then_r ? kuf_pkg::ST_CHECK : kuf_pkg::ST_IDLE;
        end
      end

      kuf_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.start_graph) begin
            done_nxt     = 1'b0;
            last_nxt     = '0;
            clr_then_nxt = 1'b1;
            state_nxt    = kuf_pkg::ST_CLEAR;
          end else begin
            state_nxt = kuf_pkg::ST_CHECK;
          end
        end
      end

      // reject without touching the forest, else start the from find
      kuf_pkg::ST_CHECK: begin
        if (done_r || !from_ok || !to_ok) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.edge_accepted = 1'b0;
          out_item_nxt.tree_done     = done_r;
          out_item_nxt.merged_size   = last_r;
          out_item_nxt.edge_from     = item_r.from_vertex;
          out_item_nxt.edge_to       = item_r.to_vertex;
          state_nxt                  = kuf_pkg::ST_IDLE;
        end else begin
          cur_nxt     = from_idx;
          ram_raddr   = from_idx;
          phase_b_nxt = 1'b0;
          state_nxt   = kuf_pkg::ST_FIND;
        end
      end

      // follow parent links, one read per cycle
      kuf_pkg::ST_FIND: begin
        if (rd_parent == cur_r) begin
          root_nxt = cur_r;
          if (phase_b_r) begin
            sb_nxt = rd_size;
          end else begin
            sa_nxt = rd_size;
          end
          cur_nxt   = start_idx;
          ram_raddr = start_idx;
          state_nxt = kuf_pkg::ST_COMP;
        end else begin
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end

      // walk the path again, pointing each node at the root
      kuf_pkg::ST_COMP: begin
        if (cur_r == root_r) begin
          if (!phase_b_r) begin
            ra_nxt      = root_r;
            phase_b_nxt = 1'b1;
            cur_nxt     = to_idx;
            ram_raddr   = to_idx;
            state_nxt   = kuf_pkg::ST_FIND;
          end else if (ra_r == root_r) begin
            // same set or self loop
            out_valid_nxt              = 1'b1;
            out_item_nxt.edge_accepted = 1'b0;
            out_item_nxt.tree_done     = done_r;
            out_item_nxt.merged_size   = last_r;
            out_item_nxt.edge_from     = item_r.from_vertex;
            out_item_nxt.edge_to       = item_r.to_vertex;
            state_nxt                  = kuf_pkg::ST_IDLE;
          end else begin
            // hang the smaller root under the larger one
            ram_we    = 1'b1;
            ram_waddr = loser;
            ram_wdata = {winner, merged};
            state_nxt = kuf_pkg::ST_UNION;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = {root_r, rd_size};
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end

      // store the merged size at the surviving root
      kuf_pkg::ST_UNION: begin
        ram_we                     = 1'b1;
        ram_waddr                  = winner;
        ram_wdata                  = {winner, merged};
        last_nxt                   = kuf_pkg::SIZE_OUT_W'(merged);
        done_nxt                   = merged_full;
        out_valid_nxt              = 1'b1;
        out_item_nxt.edge_accepted = 1'b1;
        out_item_nxt.tree_done     = merged_full;
        out_item_nxt.merged_size   = kuf_pkg::SIZE_OUT_W'(merged);
        out_item_nxt.edge_from     = item_r.from_vertex;
        out_item_nxt.edge_to       = item_r.to_vertex;
        state_nxt                  = kuf_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = kuf_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kuf_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_then_r  <= 1'b0;
      phase_b_r   <= 1'b0;
      done_r      <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_then_r  <= clr_then_nxt;
      phase_b_r   <= phase_b_nxt;
      done_r      <= done_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    ra_r       <= ra_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    out_item_r <= out_item_nxt;
  end

  // register port, word decode on paddr[2]
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= kuf_pkg::VCOUNT_RESET;
    end else if (cfg_wr && (paddr[2] == kuf_pkg::REG_VERTEX_COUNT)) begin
      vcount_r <= pwdata[kuf_pkg::VCOUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == kuf_pkg::REG_VERTEX_COUNT) ?
                  kuf_pkg::APB_DW'(vcount_r) : '0;
  assign pready = 1'b1;

  assign busy      = state_r != kuf_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/kuf_ram.sv =====
// ----------------------------------------------------------------------------
// kuf_ram
// simple dual-port ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/kuf_checker.sv =====
// ----------------------------------------------------------------------------
// kuf_checker
// port-level checks on the union-find edge filter
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire kuf_pkg::out_item_t out_item,
  input wire logic               pready
);

  // an accepted edge keeps the block busy on the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an edge transfer");

  // a result only shows once the sequencer is back at rest
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // at most one result per edge, never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a union always joins at least two vertices
  a_union_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.edge_accepted) |-> (out_item.merged_size >= 9'd2))
    else $error("accepted edge with merged size below two");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item),
  .pready    (pready)
);

`default_nettype wire
